[design/brf_pkg.sv]
// Package: shared constants, types and count helper for the byte ring FIFO.
`timescale 1ns / 1ps

package brf_pkg;

    localparam int DEPTH    = 256;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = 9;
    localparam int BYTE_W   = 8;
    localparam int REQ_W    = 2;
    localparam int M_DATA_W = 32;

    localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(256);
    localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(DEPTH);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FORCE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;   // latch the input item, sample ring at read pointer
        logic commit;     // apply the request and load the result register
        logic cfg_write;  // new ring length, pointers cleared
    } brf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // result register can take a new item this cycle
    } brf_status_t;

    // Bytes held, from pointers and wrap bits.
    function automatic cnt_t held_count(ptr_t rp, ptr_t wp, logic rw, logic ww, cnt_t len);
        cnt_t r;
        if (rp == wp) begin
            r = (rw == ww) ? '0 : len;
        end else if (wp > rp) begin
            r = {1'b0, wp} - {1'b0, rp};
        end else begin
            r = len - {1'b0, rp} + {1'b0, wp};
        end
        return r;
    endfunction

endpackage

[design/brf_ctrl.sv]
// Controller: two-state sequencer for request accept and execute.
`timescale 1ns / 1ps

module brf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  brf_pkg::brf_status_t status,
    output brf_pkg::brf_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        cfg_ready     = (state_reg == ST_IDLE);
        s_tready      = (state_reg == ST_IDLE) && !cfg_valid;
        cmd.cfg_write = cfg_valid && cfg_ready;
        cmd.load_req  = s_tvalid && s_tready;
        cmd.commit    = (state_reg == ST_EXEC) && status.out_free;
        state_next    = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load_req) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[design/brf_datapath.sv]
// Datapath: ring storage, pointers with wrap bits, counts and result register.
`timescale 1ns / 1ps

module brf_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  brf_pkg::brf_cmd_t             cmd,
    output brf_pkg::brf_status_t          status,
    input  logic [brf_pkg::REQ_W-1:0]     req_type,
    input  logic [brf_pkg::BYTE_W-1:0]    push_data,
    input  logic [brf_pkg::CNT_W-1:0]     cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [brf_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [0:0]                    m_tuser
);

    logic [brf_pkg::BYTE_W-1:0] ring_mem [brf_pkg::DEPTH];
    logic [brf_pkg::BYTE_W-1:0] rd_data_reg;

    brf_pkg::cnt_t              size_reg;
    brf_pkg::ptr_t              rp_reg;
    brf_pkg::ptr_t              wp_reg;
    logic                       rw_reg;
    logic                       ww_reg;
    logic [brf_pkg::REQ_W-1:0]  req_reg;
    logic [brf_pkg::BYTE_W-1:0] byte_reg;

    logic                        out_valid_reg;
    logic [brf_pkg::M_DATA_W-1:0] out_data_reg;
    logic                        out_acc_reg;

    brf_pkg::cnt_t len;
    brf_pkg::cnt_t cnt_now;
    brf_pkg::cnt_t cnt_after;
    brf_pkg::cnt_t space_after;
    logic          full;
    logic          empty;
    logic          wp_wrap;
    logic          rp_wrap;
    brf_pkg::ptr_t wp_adv;
    brf_pkg::ptr_t rp_adv;
    logic          do_store;
    logic          ok;
    logic [brf_pkg::BYTE_W-1:0] pop_byte;

    assign status.out_free = !out_valid_reg || m_tready;

    always_comb begin
        len       = (size_reg > brf_pkg::DEPTH_CNT) ? brf_pkg::DEPTH_CNT : size_reg;
        cnt_now   = brf_pkg::held_count(rp_reg, wp_reg, rw_reg, ww_reg, len);
        full      = (cnt_now >= len);
        empty     = (cnt_now == '0);
        wp_wrap   = ({1'b0, wp_reg} + brf_pkg::CNT_W'(1)) >= len;
        rp_wrap   = ({1'b0, rp_reg} + brf_pkg::CNT_W'(1)) >= len;
        wp_adv    = wp_wrap ? '0 : wp_reg + brf_pkg::PTR_W'(1);
        rp_adv    = rp_wrap ? '0 : rp_reg + brf_pkg::PTR_W'(1);
        ok        = 1'b0;
        do_store  = 1'b0;
        pop_byte  = '0;
        cnt_after = cnt_now;
        if (len != '0) begin
            case (req_reg)
                brf_pkg::REQ_PUSH: begin
                    if (!full) begin
                        ok        = 1'b1;
                        do_store  = 1'b1;
                        cnt_after = cnt_now + brf_pkg::CNT_W'(1);
                    end
                end
                brf_pkg::REQ_FORCE: begin
                    ok        = 1'b1;
                    do_store  = 1'b1;
                    cnt_after = full ? len : cnt_now + brf_pkg::CNT_W'(1);
                end
                brf_pkg::REQ_POP: begin
                    if (!empty) begin
                        ok        = 1'b1;
                        pop_byte  = rd_data_reg;
                        cnt_after = cnt_now - brf_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    ok        = 1'b1;
                    cnt_after = '0;
                end
            endcase
        end
        space_after = len - cnt_after;
    end

    // Ring storage; read data sampled at the read pointer every cycle
    always_ff @(posedge aclk) begin
        if (cmd.commit && do_store) begin
            ring_mem[wp_reg] <= byte_reg;
        end
        rd_data_reg <= ring_mem[rp_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg  <= req_type;
            byte_reg <= push_data;
        end
        if (cmd.commit) begin
            out_data_reg <= brf_pkg::M_DATA_W'({space_after, cnt_after, pop_byte});
            out_acc_reg  <= ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= brf_pkg::SIZE_RESET;
            rp_reg        <= '0;
            wp_reg        <= '0;
            rw_reg        <= 1'b0;
            ww_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.cfg_write) begin
                size_reg <= cfg_data;
                rp_reg   <= '0;
                wp_reg   <= '0;
                rw_reg   <= 1'b0;
                ww_reg   <= 1'b0;
            end else if (cmd.commit && ok) begin
                case (req_reg)
                    brf_pkg::REQ_PUSH: begin
                        wp_reg <= wp_adv;
                        ww_reg <= ww_reg ^ wp_wrap;
                    end
                    brf_pkg::REQ_FORCE: begin
                        wp_reg <= wp_adv;
                        ww_reg <= ww_reg ^ wp_wrap;
                        if (full) begin
                            rp_reg <= wp_adv;
                            rw_reg <= rw_reg ^ wp_wrap;
                        end
                    end
                    brf_pkg::REQ_POP: begin
                        rp_reg <= rp_adv;
                        rw_reg <= rw_reg ^ rp_wrap;
                    end
                    default: begin
                        rp_reg <= '0;
                        wp_reg <= '0;
                        rw_reg <= 1'b0;
                        ww_reg <= 1'b0;
                    end
                endcase
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_acc_reg;

endmodule

[design/byte_ring_fifo_overwrite_core.sv]
// Top level: byte ring FIFO with overwrite, stream ports and length register.
`timescale 1ns / 1ps

// Byte FIFO over a ring of 256 entries whose in-use length comes from the
// cfg channel (reset 256, values above 256 act as 256, zero refuses every
// request). Each input item is a push, a force push (overwrites the oldest
// byte when full), a pop or a clear; each gives exactly one result item with
// the popped byte, an accepted flag, and the fill and free counts after the
// request. An item is first latched and the ring sampled at the read pointer
// (the storage read is registered), then applied and loaded into the result
// register once it is free; the next item is taken right after, while the
// result may still wait for m_tready. Writing the length clears the pointers
// but keeps stored bytes; write it only while the block is idle.

module byte_ring_fifo_overwrite_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Request items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] push_data
    input  logic [1:0]  s_tuser,    // [1:0] req_type
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] pop_data, [16:8] data_count,
                                    // [25:17] space_count, [31:26] zero
    output logic [0:0]  m_tuser,    // [0] accepted
    // Ring length register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data    // buffer_size
);

    brf_pkg::brf_cmd_t    cmd;
    brf_pkg::brf_status_t status;

    brf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    brf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .req_type  (s_tuser),
        .push_data (s_tdata),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
